FILE: src/b64d_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One decoded group handed from the front end to the back end.
  typedef struct packed {
    logic [23:0] triple;     // packed quartet, first byte in the top bits
    logic [1:0]  count;      // beats in this group, 1 to 3
    logic        has_bytes;  // 0 for a bare end-of-text marker
    logic        last;       // group closes the string
    logic        status;     // 1 if the string is invalid
  } group_t;

  // Map a character to {not_in_alphabet, sextet}; '=' maps to sextet zero.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        r = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = {1'b0, 6'd62};
      end else if (c == 8'h2F) begin
        r = {1'b0, 6'd63};
      end else if (c == PAD_CHAR) begin
        r = {1'b0, 6'd0};
      end else begin
        r = {1'b1, 6'd0};
      end
      return r;
    end
  endfunction

endpackage

FILE: src/b64d_front.sv
// Front end: classifies characters, tracks quartet state and forms decoded groups.
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       has_char,
  input  logic       end_of_text,
  output logic       emit,
  output group_t     group
);

  logic [1:0]  pos, pos_next;
  logic [17:0] accum, accum_next;
  logic        pad3, pad3_next;
  logic        qinv, qinv_next;
  logic        padded, padded_next;
  logic        err, err_next;

  logic [6:0]  sx;
  logic        is_pad;
  logic        qinv_now;
  logic        err_now;
  logic [1:0]  cnt;

  always_comb begin
    sx          = sextet_of(char_code);
    is_pad      = (char_code == PAD_CHAR);
    pos_next    = pos;
    accum_next  = accum;
    pad3_next   = pad3;
    qinv_next   = qinv;
    padded_next = padded;
    err_next    = err;
    qinv_now    = qinv;
    err_now     = err;
    cnt         = 2'd0;
    emit        = 1'b0;
    group       = '0;
    if (accept) begin
      if (has_char) begin
        qinv_now = qinv | sx[6] | padded | (is_pad & (pos < 2'd2));
        if (pos != 2'd3) begin
          pad3_next  = pad3 | ((pos == 2'd2) & is_pad);
          accum_next = {accum[11:0], sx[5:0]};
          pos_next   = pos + 2'd1;
          qinv_next  = qinv_now;
        end else begin
          qinv_now = qinv_now | (pad3 & ~is_pad);
          err_now  = err | qinv_now;
          if (!err_now) begin
            cnt          = 2'd1 + {1'b0, ~pad3} + {1'b0, ~is_pad};
            group.triple = {accum, sx[5:0]};
          end
          padded_next = padded | is_pad;
          pos_next    = 2'd0;
          accum_next  = '0;
          pad3_next   = 1'b0;
          qinv_next   = 1'b0;
          err_next    = err_now;
        end
      end
      group.count     = cnt;
      group.has_bytes = (cnt != 2'd0);
      if (end_of_text) begin
        group.last   = 1'b1;
        group.status = err_next | qinv_next | (pos_next != 2'd0);
        if (cnt == 2'd0) begin
          group.count = 2'd1;
        end
        // string closes: drop all quartet state
        pos_next    = 2'd0;
        accum_next  = '0;
        pad3_next   = 1'b0;
        qinv_next   = 1'b0;
        padded_next = 1'b0;
        err_next    = 1'b0;
      end
      emit = (cnt != 2'd0) | end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 2'd0;
      accum  <= '0;
      pad3   <= 1'b0;
      qinv   <= 1'b0;
      padded <= 1'b0;
      err    <= 1'b0;
    end else begin
      pos    <= pos_next;
      accum  <= accum_next;
      pad3   <= pad3_next;
      qinv   <= qinv_next;
      padded <= padded_next;
      err    <= err_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (pos == 2'd0 && !err && !padded && !qinv))
    else $error("string state not cleared at end of text");

  a_no_bytes_after_error: assert property (@(posedge clk) disable iff (rst)
    (emit && group.has_bytes) |-> !err)
    else $error("bytes emitted after an error");

endmodule

FILE: src/b64d_queue.sv
// Short group queue between the front end and the back end.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  output logic   head_valid,
  output group_t head_data,
  input  logic   pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("group queue count out of range");

endmodule

FILE: src/b64d_back.sv
// Back end: splits queued groups into result beats behind an output register.
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  group_t     head_data,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       status
);

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       final_beat;
  logic [7:0] sel_byte;

  assign empty      = ~out_valid;
  assign load       = head_valid & (~out_valid | pop);
  assign final_beat = (idx == head_data.count - 2'd1);
  assign head_pop   = load & final_beat;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head_data.triple[23:16];
      2'd1:    sel_byte = head_data.triple[15:8];
      default: sel_byte = head_data.triple[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_beat ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte  <= head_data.has_bytes ? sel_byte : 8'd0;
      byte_valid <= head_data.has_bytes;
      last       <= final_beat & head_data.last;
      status     <= final_beat & head_data.status;
    end
  end

endmodule

FILE: src/base64_decoder_stream.sv
// Base64 stream decoder: top level joining front end, group queue and back end.
//
// Takes one character item per cycle while full is low. A completed quartet
// yields up to three byte beats, and the end of a string adds a final beat with
// last and status (a beat with byte_valid low if no byte is left to carry them).
// The input side never waits on decoding itself; full rises only when QUEUE_DEPTH
// decoded groups are waiting, which is set by the result side draining one beat
// per cycle while pop is held, through its output register. A result is held in
// the queue, then the output register. On status 1 discard the string's bytes.
module base64_decoder_stream
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       has_char,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       status
);

  logic   accept;
  logic   emit;
  group_t group;
  logic   head_valid;
  group_t head_data;
  logic   head_pop;

  assign accept = push & ~full;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .has_char    (has_char),
    .end_of_text (end_of_text),
    .emit        (emit),
    .group       (group)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (emit),
    .push_data  (group),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (head_pop)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> last)
    else $error("status set on a beat that is not last");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (last && data_byte == 8'd0))
    else $error("byteless beat that is not the end marker");

endmodule
